[rtl/cidebc_pkg.sv]
package cidebc_pkg;

  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_LOCAL   = 3'd1,
    TGT_IDE     = 3'd2,
    TGT_IDE_ALT = 3'd3,
    TGT_SRAM    = 3'd4,
    TGT_FLASH   = 3'd5
  } target_t;

  typedef logic signed [10:0] bank_t;

  // Offsets within the control page
  localparam logic [6:0] REG_STATUS_END = 7'h10;
  localparam logic [6:0] REG_LEFT_PAGE  = 7'h08;
  localparam logic [6:0] REG_RIGHT_PAGE = 7'h0A;
  localparam logic [6:0] REG_KEY_LO     = 7'h0C;
  localparam logic [6:0] REG_KEY_HI     = 7'h0D;
  localparam logic [6:0] REG_POWER      = 7'h0E;
  localparam logic [6:0] REG_CONTROL    = 7'h0F;

  // Address decode: upper bits of the CPU address
  localparam logic [2:0] WIN_RIGHT_HI = 3'b100;
  localparam logic [2:0] WIN_LEFT_HI  = 3'b101;
  localparam logic [8:0] PAGE_CTRL_HI = 9'h1AA;
  localparam logic [8:0] PAGE_KEY_HI  = 9'h1AB;

  localparam logic [7:0] STATUS_BASE  = 8'h1F;
  localparam logic [7:0] CONTROL_MASK = 8'hFD;
  localparam logic [7:0] CONTROL_INIT = 8'h30;

  localparam logic [1:0] KEY_SRAM_RW = 2'd0;
  localparam logic [1:0] KEY_SRAM_RO = 2'd1;
  localparam logic [1:0] KEY_FLASH   = 2'd2;

  localparam logic [1:0] KIND_FLASH   = 2'd0;
  localparam logic [1:0] KIND_SRAM    = 2'd1;
  localparam logic [1:0] KIND_SRAM_RO = 2'd2;

  function automatic bank_t bank_of(input logic [1:0] sel, input logic [5:0] page);
    bank_t b;
    if (sel == 2'd3) begin
      b = '1;
    end else begin
      b = {1'b0, sel, 2'b00, page};
    end
    return b;
  endfunction

endpackage

[rtl/cartridge_ide_bank_controller.sv]
// An accepted input item passes the input register, then decode and state update
// into the result register, before its result shows on the master side.
// Throughput: one item per cycle while the master side takes results; the input
// register holds a new item while a result waits; all state is read and written in one stage.
// Reset (rst, synchronous): banks left 0 / right off, control 0x30, card unpowered
// and in reset, both pipeline stages empty, remap disabled.
module cartridge_ide_bank_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // cpld_extended
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,       // bus_address[15:0], write_data[23:16], card_present[24]
  input  logic        s_tuser,       // mode (0 read, 1 write)
  output logic        m_tvalid,
  input  logic        m_tready,
  // target[2:0], target_address[21:3], read_data[29:22], forward_write[30],
  // left_bank_now[41:31], right_bank_now[52:42], ide_reset[53], card_led[54]
  output logic [55:0] m_tdata
);
  import cidebc_pkg::*;

  logic        cpld_extended;

  // input register
  logic        s1_valid;
  logic        s1_mode;
  logic [15:0] s1_addr;
  logic [7:0]  s1_wdata;
  logic        s1_present;

  // block state
  logic        card_powered, card_in_reset, alt_status_sel;
  logic        power_bit_latch, reset_bit_latch;
  logic [5:0]  left_page, right_page;
  logic [18:0] keyhole_offset;
  logic [7:0]  control_byte;
  bank_t       left_bank, right_bank;

  logic        card_powered_next, card_in_reset_next, alt_status_sel_next;
  logic        power_bit_latch_next, reset_bit_latch_next;
  logic [5:0]  left_page_next, right_page_next;
  logic [18:0] keyhole_offset_next;
  logic [7:0]  control_byte_next;
  bank_t       left_bank_next, right_bank_next;

  target_t     tgt;
  logic [18:0] ta;
  logic [7:0]  rd;
  logic        fwd;
  logic        pw_eff, rst_eff, alt_eff;
  logic        in_right, in_left;
  bank_t       win_bank;
  logic [18:0] key_addr;
  logic [6:0]  reg_off;
  logic        pw_bit, rs_bit;

  logic        out_adv;

  assign out_adv  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cpld_extended <= 1'b0;
    end else if (cfg_wr_en) begin
      cpld_extended <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      s1_mode    <= s_tuser;
      s1_addr    <= s_tdata[15:0];
      s1_wdata   <= s_tdata[23:16];
      s1_present <= s_tdata[24];
    end
  end

  always_comb begin
    // absent card forces the power machine off before the access is decoded
    pw_eff  = card_powered & s1_present;
    rst_eff = card_in_reset | ~s1_present;
    alt_eff = alt_status_sel & s1_present;

    card_powered_next    = pw_eff;
    card_in_reset_next   = rst_eff;
    alt_status_sel_next  = alt_eff;
    power_bit_latch_next = power_bit_latch;
    reset_bit_latch_next = reset_bit_latch;
    left_page_next       = left_page;
    right_page_next      = right_page;
    keyhole_offset_next  = keyhole_offset;
    control_byte_next    = control_byte;
    left_bank_next       = left_bank;
    right_bank_next      = right_bank;

    tgt = TGT_NONE;
    ta  = '0;
    rd  = '0;

    pw_bit = s1_wdata[1];
    rs_bit = ~s1_wdata[0];

    in_right = (s1_addr[15:13] == WIN_RIGHT_HI);
    in_left  = (s1_addr[15:13] == WIN_LEFT_HI);
    win_bank = in_right ? right_bank : left_bank;
    key_addr = keyhole_offset + {12'd0, s1_addr[6:0]};
    reg_off  = (cpld_extended && s1_addr[6]) ? 7'd0 : s1_addr[6:0];

    if (in_right || in_left) begin
      if (!win_bank[10]) begin
        ta = {win_bank[5:0], s1_addr[12:0]};
        case (win_bank[9:8])
          KIND_FLASH: tgt = TGT_FLASH;
          KIND_SRAM:  tgt = TGT_SRAM;
          KIND_SRAM_RO: begin
            if (!s1_mode) begin
              tgt = TGT_SRAM;
            end else begin
              ta = '0;
            end
          end
          default: ta = '0;
        endcase
      end
    end else if (s1_addr[15:7] == PAGE_KEY_HI) begin
      case (control_byte[3:2])
        KEY_SRAM_RW: begin
          tgt = TGT_SRAM;
          ta  = key_addr;
        end
        KEY_SRAM_RO: begin
          if (!s1_mode) begin
            tgt = TGT_SRAM;
            ta  = key_addr;
          end
        end
        KEY_FLASH: begin
          tgt = TGT_FLASH;
          ta  = key_addr;
        end
        default: ;
      endcase
    end else if (s1_addr[15:7] == PAGE_CTRL_HI) begin
      if (reg_off[6:3] == 4'd0) begin
        if (pw_eff) begin
          tgt = alt_eff ? TGT_IDE_ALT : TGT_IDE;
          ta  = {16'd0, reg_off[2:0]};
        end else if (!s1_mode) begin
          tgt = TGT_LOCAL;
          rd  = 8'hFF;
        end
      end else if (!s1_mode) begin
        if (reg_off < REG_STATUS_END) begin
          tgt = TGT_LOCAL;
          rd  = STATUS_BASE | {s1_present, ~rst_eff, pw_eff, 5'd0};
        end
      end else begin
        unique case (reg_off)
          REG_LEFT_PAGE: begin
            left_page_next = s1_wdata[5:0];
            left_bank_next = bank_of(control_byte[7:6], s1_wdata[5:0]);
            tgt = TGT_LOCAL;
          end
          REG_RIGHT_PAGE: begin
            right_page_next = s1_wdata[5:0];
            right_bank_next = bank_of(control_byte[5:4], s1_wdata[5:0]);
            tgt = TGT_LOCAL;
          end
          REG_KEY_LO: begin
            keyhole_offset_next = {keyhole_offset[18:15], s1_wdata, 7'd0};
            tgt = TGT_LOCAL;
          end
          REG_KEY_HI: begin
            keyhole_offset_next = {s1_wdata[3:0], keyhole_offset[14:7], 7'd0};
            tgt = TGT_LOCAL;
          end
          REG_POWER: begin
            if (s1_present) begin
              if (!pw_eff) begin
                if (pw_bit && !power_bit_latch) card_powered_next = 1'b1;
              end else if (!pw_bit) begin
                card_powered_next   = 1'b0;
                card_in_reset_next  = 1'b1;
                alt_status_sel_next = 1'b0;
              end else if (rst_eff) begin
                if (!rs_bit && reset_bit_latch) card_in_reset_next = 1'b0;
              end else begin
                alt_status_sel_next = rs_bit;
              end
              power_bit_latch_next = pw_bit;
              reset_bit_latch_next = rs_bit;
            end
            tgt = TGT_LOCAL;
          end
          REG_CONTROL: begin
            control_byte_next = s1_wdata & CONTROL_MASK;
            left_bank_next    = bank_of(s1_wdata[7:6], left_page);
            right_bank_next   = bank_of(s1_wdata[5:4], right_page);
            tgt = TGT_LOCAL;
          end
          default: ;
        endcase
      end
    end

    fwd = s1_mode && (tgt != TGT_NONE) && (tgt != TGT_LOCAL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      card_powered    <= 1'b0;
      card_in_reset   <= 1'b1;
      alt_status_sel  <= 1'b0;
      power_bit_latch <= 1'b0;
      reset_bit_latch <= 1'b1;
      left_page       <= '0;
      right_page      <= '0;
      keyhole_offset  <= '0;
      control_byte    <= CONTROL_INIT;
      left_bank       <= '0;
      right_bank      <= '1;
    end else if (out_adv) begin
      card_powered    <= card_powered_next;
      card_in_reset   <= card_in_reset_next;
      alt_status_sel  <= alt_status_sel_next;
      power_bit_latch <= power_bit_latch_next;
      reset_bit_latch <= reset_bit_latch_next;
      left_page       <= left_page_next;
      right_page      <= right_page_next;
      keyhole_offset  <= keyhole_offset_next;
      control_byte    <= control_byte_next;
      left_bank       <= left_bank_next;
      right_bank      <= right_bank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= s1_valid;
    end
    if (out_adv) begin
      m_tdata <= {1'b0,
                  card_powered_next,
                  ~card_powered_next | card_in_reset_next | ~s1_present,
                  right_bank_next,
                  left_bank_next,
                  fwd,
                  rd,
                  ta,
                  tgt};
    end
  end

`ifndef ASSERT_OFF
  // a held input item stays until the result register frees up
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_adv |=> s1_valid)
    else $error("input stage dropped an item");

  a_fwd_routed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[30] |-> (m_tdata[2:0] != TGT_NONE) && (m_tdata[2:0] != TGT_LOCAL))
    else $error("forward_write on a non-routed result");

  a_rd_local: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[29:22] != 8'd0) |-> (m_tdata[2:0] == TGT_LOCAL))
    else $error("read_data on a non-local result");

  // an IDE access names only a task-file register and needs a powered card, which may still be in reset
  a_ide_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == TGT_IDE || m_tdata[2:0] == TGT_IDE_ALT)
      |-> (m_tdata[21:6] == 16'd0) && m_tdata[54])
    else $error("IDE access with bad register or unpowered card");

  a_led_reset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[54] |-> m_tdata[53])
    else $error("unpowered card not held in reset");
`endif

endmodule
